### hdl/scbg_pkg.sv
package scbg_pkg;

    localparam int MAX_PIXELS_DEF = 64;

    localparam int SCORE_W     = 8;
    localparam int LED_COUNT_W = 7;
    localparam int INDEX_W     = 6;
    localparam int COLOR_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CLAMP_W     = 7;
    localparam int NUM_W       = 12;
    localparam int RECIP_W     = 13;
    localparam int RPROD_W     = NUM_W + RECIP_W;

    localparam logic [CFG_INDEX_W-1:0] REG_LED_COUNT     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_ORDER = 2'd1;

    localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST = 7'd30;

    localparam logic [CLAMP_W-1:0] SCORE_FULL = 7'd100;
    localparam logic [CLAMP_W-1:0] SEG_YELLOW = 7'd50;
    localparam logic [CLAMP_W-1:0] SEG_ORANGE = 7'd80;
    localparam logic [COLOR_W-1:0] COLOR_MAX  = 8'd255;
    localparam logic [COLOR_W-1:0] ORANGE_G   = 8'd165;
    localparam logic [NUM_W-1:0]   RED_SLOPE  = 12'd51;
    // 6554 / 2^16 ~ 1/10, exact floor for numerators up to 2550
    localparam logic [RECIP_W-1:0] RECIP_TEN  = 13'd6554;
    localparam int                 RECIP_SH   = 16;
    localparam int                 THR_STEP   = 100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        logic load;
        logic calc;
        logic div;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

endpackage

### hdl/scbg_ctrl.sv
module scbg_ctrl
    import scbg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (out_ready && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL:
            begin
                cmd.calc = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div = 1'b1;
            end
            ST_SWEEP:
            begin
                out_valid = 1'b1;
                cmd.step  = out_ready && !status.last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### hdl/scbg_dp.sv
module scbg_dp
    import scbg_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LED_COUNT_W-1:0] cfg_data,
    input  logic [SCORE_W-1:0]     level_score,
    output logic [INDEX_W-1:0]     pixel_index,
    output logic [COLOR_W-1:0]     red_level,
    output logic [COLOR_W-1:0]     green_level,
    output logic                   last_pixel
);

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int PROD_W = $clog2(THR_STEP * MAX_PIXELS + 1);

    logic [LED_COUNT_W-1:0] led_count_reg, led_count_next;
    logic                   reverse_reg, reverse_next;
    logic [CLAMP_W-1:0]     score_reg, score_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [PROD_W-1:0]      thr_reg, thr_next;
    logic [CNT_W-1:0]       pix_reg, pix_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [COLOR_W-1:0]     red_reg, red_next;
    logic [COLOR_W-1:0]     green_reg, green_next;

    logic [CLAMP_W-1:0]     score_clamp;
    logic [CNT_W-1:0]       count_eff;
    logic [CNT_W-1:0]       count_last;
    logic [CNT_W-1:0]       idx;
    logic [RPROD_W-1:0]     red_prod;
    logic [CLAMP_W-1:0]     seg_diff;
    logic [9:0]             seg_scaled;
    logic                   lit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= LED_COUNT_RST;
            reverse_reg   <= 1'b0;
        end
        else
        begin
            led_count_reg <= led_count_next;
            reverse_reg   <= reverse_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        count_reg <= count_next;
        prod_reg  <= prod_next;
        thr_reg   <= thr_next;
        pix_reg   <= pix_next;
        num_reg   <= num_next;
        red_reg   <= red_next;
        green_reg <= green_next;
    end

    always_comb
    begin
        led_count_next = led_count_reg;
        reverse_next   = reverse_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LED_COUNT:     led_count_next = cfg_data;
                REG_REVERSE_ORDER: reverse_next   = cfg_data[0];
                default:           led_count_next = led_count_reg;
            endcase
        end
    end

    always_comb
    begin
        if (level_score > SCORE_W'(SCORE_FULL))
        begin
            score_clamp = SCORE_FULL;
        end
        else
        begin
            score_clamp = level_score[CLAMP_W-1:0];
        end

        if (led_count_reg == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (led_count_reg > LED_COUNT_W'(MAX_PIXELS))
        begin
            count_eff = CNT_W'(MAX_PIXELS);
        end
        else
        begin
            count_eff = CNT_W'(led_count_reg);
        end
    end

    always_comb
    begin
        red_prod   = RPROD_W'(num_reg) * RPROD_W'(RECIP_TEN);
        seg_diff   = (score_reg > SEG_ORANGE) ? (score_reg - SEG_ORANGE)
                                              : (score_reg - SEG_YELLOW);
        seg_scaled = (score_reg > SEG_ORANGE) ? (10'(seg_diff) * 10'd33) >> 2
                                              : 10'(seg_diff) * 10'd3;
    end

    always_comb
    begin
        score_next = score_reg;
        count_next = count_reg;
        prod_next  = prod_reg;
        thr_next   = thr_reg;
        pix_next   = pix_reg;
        num_next   = num_reg;
        red_next   = red_reg;
        green_next = green_reg;

        if (cmd.load)
        begin
            score_next = score_clamp;
            count_next = count_eff;
        end

        if (cmd.calc)
        begin
            prod_next = PROD_W'(score_reg) * PROD_W'(count_reg);
            num_next  = NUM_W'(score_reg) * RED_SLOPE;
            thr_next  = PROD_W'(THR_STEP);
            pix_next  = '0;
            if (score_reg <= SEG_YELLOW)
            begin
                green_next = COLOR_MAX;
            end
            else if (score_reg <= SEG_ORANGE)
            begin
                green_next = COLOR_MAX - seg_scaled[COLOR_W-1:0];
            end
            else
            begin
                green_next = ORANGE_G - seg_scaled[COLOR_W-1:0];
            end
        end

        if (cmd.div)
        begin
            if (score_reg <= SEG_YELLOW)
            begin
                red_next = red_prod[RECIP_SH +: COLOR_W];
            end
            else
            begin
                red_next = COLOR_MAX;
            end
        end

        if (cmd.step)
        begin
            pix_next = pix_reg + CNT_W'(1);
            thr_next = thr_reg + PROD_W'(THR_STEP);
        end
    end

    // the pixel sent at sweep position i is lit when 100*(i+1) <= score*count
    always_comb
    begin
        count_last  = count_reg - CNT_W'(1);
        idx         = reverse_reg ? (count_last - pix_reg) : pix_reg;
        lit         = (thr_reg <= prod_reg);
        status.last = (pix_reg == count_last);
    end

    assign pixel_index = INDEX_W'(idx);
    assign red_level   = lit ? red_reg : '0;
    assign green_level = lit ? green_reg : '0;
    assign last_pixel  = status.last;

endmodule

### hdl/score_bar_graph_pixel_driver.sv
// The first pixel transaction is offered after the accepted score passes through the
// MUL and DIV states; the sweep sends one pixel per cycle while out_ready is high,
// and the next score is taken only after the last pixel.
// Reset (rst_n, async, active low): idle, led_count = 30, reverse_order = 0.
module score_bar_graph_pixel_driver
    import scbg_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SCORE_W-1:0]     level_score,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [INDEX_W-1:0]     pixel_index,
    output logic [COLOR_W-1:0]     red_level,
    output logic [COLOR_W-1:0]     green_level,
    output logic                   last_pixel,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LED_COUNT_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    scbg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    scbg_dp #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .level_score (level_score),
        .pixel_index (pixel_index),
        .red_level   (red_level),
        .green_level (green_level),
        .last_pixel  (last_pixel)
    );

endmodule
